/* sv/light_proximity_event_processor_defines.svh */
// Assertion helpers shared by the light and proximity event processor.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef LIGHT_PROXIMITY_EVENT_PROCESSOR_DEFINES_SVH
`define LIGHT_PROXIMITY_EVENT_PROCESSOR_DEFINES_SVH
`ifndef SYNTH
`define LPEP_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define LPEP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LPEP_ASSERT(label, expr, msg)
`define LPEP_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

/* sv/lpep_pkg.sv */
package lpep_pkg;

  // Configuration port geometry.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Stream widths.
  localparam int IN_DW  = 48;
  localparam int OUT_DW = 88;

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Sensor enable bits.
  localparam int EN_LIGHT = 0;
  localparam int EN_PROX  = 1;

  // Proximity tracking.
  localparam int PROX_WAVE   = 100;
  localparam int PROX_WINDOW = 100;
  localparam logic [10:0] BASELINE_RST  = 11'd923;
  localparam logic [9:0]  PROX_LOW_RST  = 10'h31f;
  localparam logic [9:0]  PROX_HIGH_RST = 10'h320;

  // Reciprocal constants: x / N == (x * RECIP_N) >> SH_N over the value ranges used.
  localparam logic [15:0] RECIP_5   = 16'd52429;
  localparam int          SH_5      = 18;
  localparam logic [23:0] RECIP_10  = 24'd13421773;
  localparam int          SH_10     = 27;
  localparam logic [26:0] RECIP_100 = 27'd85899346;
  localparam int          SH_100    = 33;

  // Lux computation.
  localparam logic signed [26:0] LUX_MAX   = 27'sd67108863;
  localparam logic signed [26:0] LUX_FIRST = -27'sd1;
  localparam int NUM_W     = 37;
  localparam int DVSR_W    = 24;
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    REG_ALS_TIME       = 3'd0,
    REG_ALS_GAIN       = 3'd1,
    REG_GLASS_ATTEN    = 3'd2,
    REG_IR_COEF_B      = 3'd3,
    REG_CLEAR_COEF_C   = 3'd4,
    REG_IR_COEF_D      = 3'd5,
    REG_DEVICE_FACTOR  = 3'd6,
    REG_SENSOR_ENABLES = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] als_time;
    logic [6:0] als_gain;
    logic [7:0] glass_atten;
    logic [9:0] ir_coef_b;
    logic [7:0] clear_coef_c;
    logic [9:0] ir_coef_d;
    logic [7:0] device_factor;
    logic [1:0] sensor_enables;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic        prox_pending;
    logic        light_pending;
    logic [9:0]  prox_count;
    logic [15:0] clear_count;
    logic [15:0] ir_count;
  } in_item_t;

  typedef struct packed {
    logic               distance_valid;
    logic               far_flag;
    logic               light_valid;
    logic signed [26:0] lux_value;
    logic [9:0]         prox_low_out;
    logic [9:0]         prox_high_out;
    logic [15:0]        light_low_out;
    logic [15:0]        light_high_out;
    logic               prox_irq_clear;
    logic               light_irq_clear;
  } out_item_t;

  typedef struct packed {
    logic        need_lux;
    logic [15:0] clear_count;
    logic [15:0] ir_count;
    out_item_t   res;
  } qentry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_IRB,
    B_Q1,
    B_CC,
    B_Q2,
    B_IRD,
    B_Q3,
    B_ADJ,
    B_DEV,
    B_DEN,
    B_Q4,
    B_DIVSET,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

/* sv/lpep_queue.sv */
`include "light_proximity_event_processor_defines.svh"

module lpep_queue
  import lpep_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_i,
  input  qentry_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output qentry_t data_o,
  output logic    empty_o
);

  qentry_t          mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  assign full_o  = (count_r == QCW'(QDEPTH));
  assign empty_o = (count_r == '0);
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  `LPEP_ASSERT(a_q_no_overflow, count_r <= QCW'(QDEPTH), "queue holds more beats than its depth")
  `LPEP_ASSERT_IMP(a_q_pop_nonempty, pop_i, count_r != '0, "queue popped while empty")

endmodule

/* sv/lpep_front.sv */
`include "light_proximity_event_processor_defines.svh"

module lpep_front
  import lpep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  in_item_t   in_item,
  input  logic [1:0] enables,
  output logic       q_push,
  output qentry_t    q_data,
  input  logic       q_full
);

  logic [10:0] base_r, base_nxt;
  logic [9:0]  plo_r, plo_nxt;
  logic [9:0]  phi_r, phi_nxt;
  logic [15:0] llo_r, llo_nxt;
  logic [15:0] lhi_r, lhi_nxt;
  logic        first_read_r, first_read_nxt;

  logic        sample, prox_hit, light_hit;
  logic        dist_valid, far;
  logic [10:0] cand, cand_hi;
  logic [31:0] c5_prod;
  logic [13:0] c_div5;
  logic [15:0] c5_back;
  logic        rem_nz;
  logic [16:0] hi_sum;
  logic [15:0] hi_sat, lo_val;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign sample    = q_push && !in_item.action;
  assign prox_hit  = sample && in_item.prox_pending && enables[EN_PROX];
  assign light_hit = sample && in_item.light_pending && enables[EN_LIGHT];

  assign cand    = {1'b0, in_item.prox_count} + 11'(PROX_WAVE);
  assign cand_hi = cand + 11'(PROX_WINDOW);

  // Light thresholds: 6c/5 = c + c/5 and 4c/5 = c - ceil(c/5).
  assign c5_prod = in_item.clear_count * RECIP_5;
  assign c_div5  = c5_prod[31:SH_5];
  assign c5_back = {c_div5, 2'b00} + {2'b00, c_div5};
  assign rem_nz  = (c5_back != in_item.clear_count);
  assign hi_sum  = {1'b0, in_item.clear_count} + 17'(c_div5);
  assign hi_sat  = hi_sum[16] ? 16'hffff : hi_sum[15:0];
  assign lo_val  = in_item.clear_count - 16'(c_div5) - 16'(rem_nz);

  always_comb begin
    base_nxt       = base_r;
    plo_nxt        = plo_r;
    phi_nxt        = phi_r;
    llo_nxt        = llo_r;
    lhi_nxt        = lhi_r;
    first_read_nxt = first_read_r;
    dist_valid     = 1'b0;
    far            = 1'b0;
    if (q_push && in_item.action) begin
      first_read_nxt = 1'b1;
    end
    if (prox_hit) begin
      if (cand < base_r) begin
        base_nxt = cand;
        plo_nxt  = cand[9:0];
        phi_nxt  = cand_hi[9:0];
      end
      if (in_item.prox_count >= phi_nxt) begin
        plo_nxt    = base_nxt[9:0];
        dist_valid = 1'b1;
      end else if (in_item.prox_count <= plo_nxt) begin
        plo_nxt    = '0;
        dist_valid = 1'b1;
        far        = 1'b1;
      end
    end
    if (light_hit) begin
      lhi_nxt        = hi_sat;
      llo_nxt        = lo_val;
      first_read_nxt = 1'b0;
    end
  end

  always_comb begin
    q_data                     = '0;
    q_data.need_lux            = light_hit && !first_read_r;
    q_data.clear_count         = in_item.clear_count;
    q_data.ir_count            = in_item.ir_count;
    q_data.res.distance_valid  = dist_valid;
    q_data.res.far_flag        = far;
    q_data.res.light_valid     = light_hit;
    q_data.res.lux_value       = (light_hit && first_read_r) ? LUX_FIRST : '0;
    q_data.res.prox_low_out    = plo_nxt;
    q_data.res.prox_high_out   = phi_nxt;
    q_data.res.light_low_out   = llo_nxt;
    q_data.res.light_high_out  = lhi_nxt;
    q_data.res.prox_irq_clear  = sample && in_item.prox_pending;
    q_data.res.light_irq_clear = sample && in_item.light_pending;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= BASELINE_RST;
      plo_r        <= PROX_LOW_RST;
      phi_r        <= PROX_HIGH_RST;
      llo_r        <= '0;
      lhi_r        <= '0;
      first_read_r <= 1'b1;
    end else begin
      base_r       <= base_nxt;
      plo_r        <= plo_nxt;
      phi_r        <= phi_nxt;
      llo_r        <= llo_nxt;
      lhi_r        <= lhi_nxt;
      first_read_r <= first_read_nxt;
    end
  end

  `LPEP_ASSERT(a_base_never_rises, base_nxt <= base_r, "proximity baseline increased")
  `LPEP_ASSERT_IMP(a_first_read_fall, $fell(first_read_r), $past(light_hit),
    "first-read flag cleared without a light report")

endmodule

/* sv/lpep_back.sv */
`include "light_proximity_event_processor_defines.svh"

module lpep_back
  import lpep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  qentry_t   q_data,
  output logic      q_pop,
  output logic      out_tvalid,
  input  logic      out_tready,
  output out_item_t out_item
);

  back_state_t state_r, state_nxt;

  qentry_t            item_r, item_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [31:0]        mul_a, mul_b;
  logic signed [22:0] adj1_r, adj1_nxt;
  logic [20:0]        a2_r, a2_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DVSR_W-1:0]  rem_r, rem_nxt;
  logic [DVSR_W-1:0]  dvsr_r, dvsr_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  out_item_t          out_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ld;

  logic [19:0]        q_hi;
  logic signed [22:0] adj2, adj_max;
  logic [20:0]        adj_c;
  logic [8:0]         t_int;
  logic [16:0]        den_base;
  logic [16:0]        den_q;
  logic [DVSR_W-1:0]  dvsr_calc;
  logic [DVSR_W:0]    div_shift, div_diff;
  logic               div_ge;

  // Quotient of the last reciprocal multiply by 100.
  assign q_hi    = prod_r[SH_100 + 19:SH_100];
  assign adj2    = $signed({2'b00, a2_r}) - $signed({3'b000, q_hi});
  assign adj_max = (adj1_r > adj2) ? adj1_r : adj2;
  assign adj_c   = adj_max[22] ? '0 : adj_max[20:0];

  // 272 * (256 - als_time) as a shift-and-add: 272 = 256 + 16.
  assign t_int    = 9'd256 - {1'b0, cfg.als_time};
  assign den_base = {t_int, 8'b0} + {4'b0, t_int, 4'b0};

  // Divisor is 100 * floor(den / 100): 100 = 64 + 32 + 4.
  assign den_q     = prod_r[SH_100 + 16:SH_100];
  assign dvsr_calc = {1'b0, den_q, 6'b0} + {2'b0, den_q, 5'b0} + {5'b0, den_q, 2'b0};

  assign div_shift = {rem_r, num_r[NUM_W-1]};
  assign div_diff  = div_shift - {1'b0, dvsr_r};
  assign div_ge    = (div_shift >= {1'b0, dvsr_r});

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.need_lux ? B_IRB : B_OUT;
        end
      end
      B_IRB:    state_nxt = B_Q1;
      B_Q1:     state_nxt = B_CC;
      B_CC:     state_nxt = B_Q2;
      B_Q2:     state_nxt = B_IRD;
      B_IRD:    state_nxt = B_Q3;
      B_Q3:     state_nxt = B_ADJ;
      B_ADJ:    state_nxt = B_DEV;
      B_DEV:    state_nxt = B_DEN;
      B_DEN:    state_nxt = B_Q4;
      B_Q4:     state_nxt = B_DIVSET;
      B_DIVSET: state_nxt = (den_q == '0) ? B_OUT : B_DIV;
      B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_ld   = 1'b0;
    item_nxt = item_r;
    adj1_nxt = adj1_r;
    a2_nxt   = a2_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      B_IDLE: begin
        q_pop    = !q_empty;
        item_nxt = q_data;
      end
      B_IRB: begin
        mul_a = 32'(cfg.ir_coef_b);
        mul_b = 32'(item_r.ir_count);
      end
      B_Q1: begin
        mul_a = prod_r[31:0];
        mul_b = 32'(RECIP_100);
      end
      B_CC: begin
        adj1_nxt = $signed({7'b0, item_r.clear_count}) - $signed({3'b000, q_hi});
        mul_a    = 32'(cfg.clear_coef_c);
        mul_b    = 32'(item_r.clear_count);
      end
      B_Q2: begin
        mul_a = prod_r[31:0];
        mul_b = 32'(RECIP_10);
      end
      B_IRD: begin
        a2_nxt = prod_r[SH_10 + 20:SH_10];
        mul_a  = 32'(cfg.ir_coef_d);
        mul_b  = 32'(item_r.ir_count);
      end
      B_Q3: begin
        mul_a = prod_r[31:0];
        mul_b = 32'(RECIP_100);
      end
      B_ADJ: begin
        mul_a = 32'(adj_c);
        mul_b = 32'(cfg.glass_atten);
      end
      B_DEV: begin
        mul_a = prod_r[31:0];
        mul_b = 32'(cfg.device_factor);
      end
      B_DEN: begin
        num_nxt = prod_r[NUM_W-1:0];
        mul_a   = 32'(den_base);
        mul_b   = 32'(cfg.als_gain);
      end
      B_Q4: begin
        mul_a = prod_r[31:0];
        mul_b = 32'(RECIP_100);
      end
      B_DIVSET: begin
        dvsr_nxt = dvsr_calc;
        rem_nxt  = '0;
        cnt_nxt  = DCNT_W'(DIV_STEPS);
        if (den_q == '0) begin
          item_nxt.res.lux_value = LUX_MAX;
        end
      end
      B_DIV: begin
        if (cnt_r != '0) begin
          rem_nxt = div_ge ? div_diff[DVSR_W-1:0] : div_shift[DVSR_W-1:0];
          num_nxt = {num_r[NUM_W-2:0], div_ge};
          cnt_nxt = cnt_r - 1'b1;
        end else if (|num_r[NUM_W-1:26]) begin
          item_nxt.res.lux_value = LUX_MAX;
        end else begin
          item_nxt.res.lux_value = {1'b0, num_r[25:0]};
        end
      end
      B_OUT: begin
        out_ld = !out_valid_r || out_tready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = out_ld || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;
  assign out_item      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    adj1_r <= adj1_nxt;
    a2_r   <= a2_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    cnt_r  <= cnt_nxt;
    if (out_ld) begin
      out_r <= item_r.res;
    end
  end

  `LPEP_ASSERT_IMP(a_lux_only_with_light, out_valid_r && !out_r.light_valid,
    out_r.lux_value == '0, "lux value present without a light report")
  `LPEP_ASSERT_IMP(a_div_nonzero, state_r == B_DIV, dvsr_r != '0,
    "lux division running with a zero divisor")

endmodule

/* sv/light_proximity_event_processor.sv */
// Light and proximity event processor. Every input beat (a sensor interrupt sample, or the
// notice that the light reader was opened) produces exactly one result beat, in order. The
// front stage takes a beat per cycle while its two-entry queue has room: it tracks the
// proximity baseline and thresholds, reports near or far, sets the light thresholds to 80 and
// 120 percent of the clear count and decides whether a lux value is needed. The back stage
// computes lux with one shared 32x32 multiplier and a radix-2 divider: a beat that needs lux
// occupies it for ten multiply steps, one divisor setup, 37 divide steps plus a finishing
// step (no divide on a zero divisor), pick-up and hand-off; other beats only the last two.
// The lux divider therefore sets the sustained rate. The result sits in an output register,
// so the back stage keeps working while a finished result waits on out_tready. The
// configuration registers sit behind an APB-style port at byte address 4 times their index
// and should be written only while no beat is in flight.
module light_proximity_event_processor
  import lpep_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  // [0] prox_pending, [1] light_pending, [11:2] prox_count, [27:12] clear_count,
  // [43:28] ir_count, [47:44] zero
  input  logic [IN_DW-1:0]  in_tdata,
  // [0] action
  input  logic              in_tuser,

  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] far_flag, [27:1] lux_value, [37:28] prox_low_out, [47:38] prox_high_out,
  // [63:48] light_low_out, [79:64] light_high_out, [80] prox_irq_clear,
  // [81] light_irq_clear, [87:82] zero
  output logic [OUT_DW-1:0] out_tdata,
  // [0] distance_valid, [1] light_valid
  output logic [1:0]        out_tuser,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t      cfg_r, cfg_nxt;
  logic      cfg_wr;
  reg_idx_t  cfg_idx;
  in_item_t  in_item;
  out_item_t out_item;

  logic      q_push, q_full, q_pop, q_empty;
  qentry_t   q_wdata, q_rdata;

  // Configuration port. Writes complete in the access phase; pready never stalls.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALS_TIME:       cfg_nxt.als_time       = cfg_pwdata[7:0];
        REG_ALS_GAIN:       cfg_nxt.als_gain       = cfg_pwdata[6:0];
        REG_GLASS_ATTEN:    cfg_nxt.glass_atten    = cfg_pwdata[7:0];
        REG_IR_COEF_B:      cfg_nxt.ir_coef_b      = cfg_pwdata[9:0];
        REG_CLEAR_COEF_C:   cfg_nxt.clear_coef_c   = cfg_pwdata[7:0];
        REG_IR_COEF_D:      cfg_nxt.ir_coef_d      = cfg_pwdata[9:0];
        REG_DEVICE_FACTOR:  cfg_nxt.device_factor  = cfg_pwdata[7:0];
        REG_SENSOR_ENABLES: cfg_nxt.sensor_enables = cfg_pwdata[1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALS_TIME:       cfg_prdata = CFG_DW'(cfg_r.als_time);
      REG_ALS_GAIN:       cfg_prdata = CFG_DW'(cfg_r.als_gain);
      REG_GLASS_ATTEN:    cfg_prdata = CFG_DW'(cfg_r.glass_atten);
      REG_IR_COEF_B:      cfg_prdata = CFG_DW'(cfg_r.ir_coef_b);
      REG_CLEAR_COEF_C:   cfg_prdata = CFG_DW'(cfg_r.clear_coef_c);
      REG_IR_COEF_D:      cfg_prdata = CFG_DW'(cfg_r.ir_coef_d);
      REG_DEVICE_FACTOR:  cfg_prdata = CFG_DW'(cfg_r.device_factor);
      REG_SENSOR_ENABLES: cfg_prdata = CFG_DW'(cfg_r.sensor_enables);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.als_time       <= 8'd219;
      cfg_r.als_gain       <= 7'd1;
      cfg_r.glass_atten    <= 8'd48;
      cfg_r.ir_coef_b      <= 10'd223;
      cfg_r.clear_coef_c   <= 8'd7;
      cfg_r.ir_coef_d      <= 10'd142;
      cfg_r.device_factor  <= 8'd52;
      cfg_r.sensor_enables <= 2'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Unpack the input beat.
  always_comb begin
    in_item.action        = in_tuser;
    in_item.prox_pending  = in_tdata[0];
    in_item.light_pending = in_tdata[1];
    in_item.prox_count    = in_tdata[11:2];
    in_item.clear_count   = in_tdata[27:12];
    in_item.ir_count      = in_tdata[43:28];
  end

  lpep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .enables   (cfg_r.sensor_enables),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  lpep_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  lpep_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  // Pack the result beat.
  assign out_tdata = {6'b0,
                      out_item.light_irq_clear,
                      out_item.prox_irq_clear,
                      out_item.light_high_out,
                      out_item.light_low_out,
                      out_item.prox_high_out,
                      out_item.prox_low_out,
                      out_item.lux_value,
                      out_item.far_flag};
  assign out_tuser = {out_item.light_valid, out_item.distance_valid};

endmodule
